[hdl/ciobd_pkg.sv]
// Shared types, constants and helpers of the cartridge I/O bank decoder.
package ciobd_pkg;

	localparam logic [15:0] CLOCK_PORT_ADDRESS = 16'hDE5F;

	localparam logic [15:0] RAM_MASK          = 16'h7FFF;
	localparam logic [15:0] RAM_LOW_START     = 16'h1000;
	localparam logic [15:0] RAM_LOW_END       = 16'h7FFF;
	localparam logic [15:0] RAM_HIGH_START    = 16'hC000;
	localparam logic [15:0] RAM_HIGH_END      = 16'hCFFF;
	localparam logic [15:0] ROM_WIN_START     = 16'hA000;
	localparam logic [15:0] ROM_WIN_END       = 16'hBFFF;
	localparam logic [15:0] ROM_WIN_BASE      = 16'h8000;
	localparam logic [15:0] CTRL_START        = 16'hDE20;
	localparam logic [15:0] CTRL_END          = 16'hDE2F;
	localparam logic [15:0] STATUS_PORT       = 16'hDE32;
	localparam logic [15:0] BANK_PORT_LAST    = 16'hDE35;
	localparam logic [15:0] IO_ROM_START      = 16'hDE60;
	localparam logic [15:0] IO_ROM_END        = 16'hDEFF;
	localparam logic [15:0] IO_ROM_BASE       = 16'h1E00;
	localparam logic [15:0] KILL_PORT         = 16'hDEFB;
	localparam logic [15:0] MODE_16K_PORT     = 16'hDEFC;
	localparam logic [15:0] MODE_8K_PORT      = 16'hDEFD;
	localparam logic [15:0] MODE_ULTIMAX_PORT = 16'hDEFE;

	localparam logic [7:0] OPEN_BUS    = 8'hFF;
	localparam logic       VERSION_BIT = 1'b1;

	localparam logic ACTION_READ  = 1'b0;
	localparam logic ACTION_WRITE = 1'b1;

	typedef enum logic [2:0] {
		TARGET_NONE  = 3'd0,
		TARGET_RAM   = 3'd1,
		TARGET_ROM   = 3'd2,
		TARGET_DISK  = 3'd3,
		TARGET_CLOCK = 3'd4,
		TARGET_REG   = 3'd5
	} target_t;

	typedef enum logic [1:0] {
		MODE_8K      = 2'd0,
		MODE_16K     = 2'd1,
		MODE_OFF     = 2'd2,
		MODE_ULTIMAX = 2'd3
	} mode_t;

	typedef struct packed {
		logic        action;
		logic [15:0] address;
		logic [7:0]  write_data;
	} req_t;

	typedef struct packed {
		target_t     target;
		logic [15:0] ext_address;
		logic [7:0]  read_data;
		logic [7:0]  forward_data;
		logic        game_line;
		logic        exrom_line;
		mode_t       mapping_mode;
		logic        claims_cpu_access;
		logic        mapping_changed;
	} rsp_t;

	typedef struct packed {
		logic       game;
		logic       exrom;
		logic [1:0] rom_bank;
		logic       kill;
		mode_t      mode;
	} ctrl_t;

	localparam ctrl_t CTRL_RESET = '{
		game: 1'b1, exrom: 1'b0, rom_bank: 2'd0, kill: 1'b0, mode: MODE_8K
	};

	function automatic logic [7:0] status_byte(input ctrl_t c);
		return {3'b000, VERSION_BIT, c.rom_bank, c.game, c.exrom};
	endfunction

endpackage

[hdl/ciobd_req_if.sv]
// Request channel carrying one CPU bus access per transfer.
interface ciobd_req_if;
	logic              valid;
	logic              ready;
	ciobd_pkg::req_t   data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[hdl/ciobd_rsp_if.sv]
// Response channel carrying one decode result per transfer.
interface ciobd_rsp_if;
	logic              valid;
	logic              ready;
	ciobd_pkg::rsp_t   data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[hdl/cartridge_io_bank_decoder_top.sv]
// Top level of the cartridge I/O bank decoder.
// The decoder accepts one CPU access per clock cycle while the response is not
// stalled and returns one result for each: the access is captured in an input
// register, decoded against the control latches in a single combinational pass,
// and the result is held in an output register until the response transfer. The
// latches are updated in the same cycle the result is registered, so the next
// access always decodes against the state left by the previous one. A stalled
// response holds the output register, and the input register keeps taking a new
// access as long as the decoded one can move on.
module cartridge_io_bank_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	ciobd_req_if.sink   req,
	ciobd_rsp_if.source rsp
);
	import ciobd_pkg::*;

	logic  valid_s1;
	req_t  item_s1;
	logic  advance;
	ctrl_t ctrl_cur;
	ctrl_t ctrl_nxt;
	rsp_t  result;
	logic  rsp_valid_q;
	rsp_t  rsp_data_q;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (!rsp_valid_q || rsp.ready) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.data;
		end
		if (advance) begin
			rsp_data_q <= result;
		end
	end

	ciobd_decode u_decode (
		.item   (item_s1),
		.cur    (ctrl_cur),
		.nxt    (ctrl_nxt),
		.result (result)
	);

	ciobd_ctrl_regs u_ctrl_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.update (advance),
		.nxt    (ctrl_nxt),
		.cur    (ctrl_cur)
	);

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

endmodule

[hdl/ciobd_decode.sv]
// Address decode and control-latch update for one CPU access.
module ciobd_decode (
	input  ciobd_pkg::req_t  item,
	input  ciobd_pkg::ctrl_t cur,
	output ciobd_pkg::ctrl_t nxt,
	output ciobd_pkg::rsp_t  result
);
	import ciobd_pkg::*;

	logic        wr;
	logic [15:0] a;
	logic        ult_cur;
	logic        ram_win;
	logic        rom_win;
	logic [15:0] bank_base;

	assign wr        = (item.action == ACTION_WRITE);
	assign a         = item.address;
	assign ult_cur   = !cur.game && cur.exrom;
	assign ram_win   = (a >= RAM_LOW_START && a <= RAM_LOW_END) ||
		(a >= RAM_HIGH_START && a <= RAM_HIGH_END);
	assign rom_win   = (a >= ROM_WIN_START && a <= ROM_WIN_END);
	assign bank_base = {cur.rom_bank, 14'd0};

	always_comb begin
		nxt                    = cur;
		result.target          = TARGET_NONE;
		result.ext_address     = 16'd0;
		result.read_data       = OPEN_BUS;
		result.forward_data    = 8'd0;
		result.mapping_changed = 1'b0;

		if (ult_cur && ram_win) begin
			result.target       = TARGET_RAM;
			result.ext_address  = a & RAM_MASK;
			result.forward_data = wr ? item.write_data : 8'd0;
		end else if (ult_cur && rom_win) begin
			if (!wr) begin
				result.target      = TARGET_ROM;
				result.ext_address = bank_base + (a - ROM_WIN_BASE);
			end
		end else if (a >= CTRL_START && a <= CTRL_END) begin
			result.target       = TARGET_DISK;
			result.ext_address  = a;
			result.forward_data = wr ? item.write_data : 8'd0;
		end else if (!wr && a == STATUS_PORT) begin
			result.target    = TARGET_REG;
			result.read_data = status_byte(cur);
		end else if (!wr && a > STATUS_PORT && a <= BANK_PORT_LAST) begin
			result.target = TARGET_NONE;
		end else if (wr && a >= STATUS_PORT && a <= BANK_PORT_LAST) begin
			nxt.rom_bank           = a[1:0] - 2'd2;
			result.target          = TARGET_REG;
			result.mapping_changed = 1'b1;
		end else if (a == CLOCK_PORT_ADDRESS) begin
			if (!cur.kill) begin
				result.target       = TARGET_CLOCK;
				result.forward_data = wr ? item.write_data : 8'd0;
			end
		end else if (!wr && a >= IO_ROM_START && a <= IO_ROM_END) begin
			if (!cur.kill) begin
				result.target      = TARGET_ROM;
				result.ext_address = bank_base + IO_ROM_BASE + {8'd0, a[7:0]};
			end
		end else if (wr && a >= KILL_PORT && a <= IO_ROM_END && !cur.kill) begin
			result.target          = TARGET_REG;
			result.mapping_changed = 1'b1;
			unique case (a)
				KILL_PORT: begin
					nxt.kill = item.write_data[0];
					if (item.write_data[0]) begin
						nxt.mode  = MODE_OFF;
						nxt.game  = 1'b1;
						nxt.exrom = 1'b1;
					end else begin
						result.mapping_changed = 1'b0;
					end
				end
				MODE_16K_PORT: begin
					nxt.mode  = MODE_16K;
					nxt.game  = 1'b0;
					nxt.exrom = 1'b0;
				end
				MODE_8K_PORT: begin
					nxt.mode  = MODE_8K;
					nxt.game  = 1'b1;
					nxt.exrom = 1'b0;
				end
				MODE_ULTIMAX_PORT: begin
					nxt.mode  = MODE_ULTIMAX;
					nxt.game  = 1'b0;
					nxt.exrom = 1'b1;
				end
				default: begin
					nxt.mode  = MODE_OFF;
					nxt.game  = 1'b1;
					nxt.exrom = 1'b1;
				end
			endcase
		end

		result.game_line         = nxt.kill ? 1'b1 : nxt.game;
		result.exrom_line        = nxt.kill ? 1'b1 : nxt.exrom;
		result.mapping_mode      = nxt.mode;
		result.claims_cpu_access = !nxt.kill && !nxt.game && nxt.exrom && (ram_win || rom_win);
	end

endmodule

[hdl/ciobd_ctrl_regs.sv]
// Control latches: cartridge lines, ROM bank bits, kill latch and mapping mode.
module ciobd_ctrl_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             update,
	input  ciobd_pkg::ctrl_t nxt,
	output ciobd_pkg::ctrl_t cur
);
	import ciobd_pkg::*;

	ctrl_t ctrl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= CTRL_RESET;
		end else if (update) begin
			ctrl_q <= nxt;
		end
	end

	assign cur = ctrl_q;

endmodule

[hdl/ciobd_checker.sv]
// Port-level checks of the cartridge I/O bank decoder and their binding.
module ciobd_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input ciobd_pkg::rsp_t rsp_data
);
	import ciobd_pkg::*;

	// A claimed access can only happen while the lines show Ultimax.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.claims_cpu_access |->
			!rsp_data.game_line && rsp_data.exrom_line)
		else $error("claim reported outside Ultimax line levels");

	// Ultimax mode is entered only together with GAME low and EXROM high.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.mapping_mode == MODE_ULTIMAX |->
			!rsp_data.game_line && rsp_data.exrom_line)
		else $error("Ultimax mode with inconsistent lines");

	// Internal RAM is 32 KiB.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.target == TARGET_RAM |-> !rsp_data.ext_address[15])
		else $error("RAM address out of range");

	// Only a register readback drives anything other than open bus.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.target != TARGET_REG |-> rsp_data.read_data == OPEN_BUS)
		else $error("read data driven without register readback");

	// A stalled result holds until its transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("stalled result changed");

endmodule

bind cartridge_io_bank_decoder_top ciobd_checker u_ciobd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

[test/ciobd_decode_checker.sv]
// Decode checker: predicts the result of every CPU access and compares it with the response channel.
module ciobd_decode_checker (
	input  logic        clk,
	input  logic        arst_n,
	ciobd_req_if        req,
	ciobd_rsp_if        rsp,
	output int unsigned mismatches,
	output int unsigned outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import ciobd_pkg::*;

	ctrl_t      latch;
	logic       version;
	logic [7:0] bank_bytes [4];
	logic [7:0] kill_byte;
	rsp_t       pending_decodes [$];

	function automatic logic [7:0] status_now();
		return {3'b000, version, latch.rom_bank, latch.game, latch.exrom};
	endfunction

	function automatic bit ultimax_mode();
		return !latch.game && latch.exrom;
	endfunction

	function automatic bit in_ram_window(input logic [15:0] a);
		return (a >= RAM_LOW_START && a <= RAM_LOW_END) ||
			(a >= RAM_HIGH_START && a <= RAM_HIGH_END);
	endfunction

	function automatic bit in_rom_window(input logic [15:0] a);
		return a >= ROM_WIN_START && a <= ROM_WIN_END;
	endfunction

	function automatic rsp_t decode_access(input req_t acc);
		rsp_t        r;
		logic        wr;
		logic [15:0] a;
		logic [15:0] base;
		logic [1:0]  idx;
		wr = (acc.action == ACTION_WRITE);
		a = acc.address;
		base = {latch.rom_bank, 14'd0};
		r = '0;
		r.target = TARGET_NONE;
		r.read_data = OPEN_BUS;
		if (ultimax_mode() && in_ram_window(a)) begin
			r.target = TARGET_RAM;
			r.ext_address = a & RAM_MASK;
			if (wr) begin
				r.forward_data = acc.write_data;
			end
		end else if (ultimax_mode() && in_rom_window(a)) begin
			if (!wr) begin
				r.target = TARGET_ROM;
				r.ext_address = base + (a - ROM_WIN_BASE);
			end
		end else if (a >= CTRL_START && a <= CTRL_END) begin
			r.target = TARGET_DISK;
			r.ext_address = a;
			if (wr) begin
				r.forward_data = acc.write_data;
			end
		end else if (!wr && a == STATUS_PORT) begin
			r.target = TARGET_REG;
			r.read_data = status_now();
			bank_bytes[0] = r.read_data;
		end else if (!wr && a > STATUS_PORT && a <= BANK_PORT_LAST) begin
			r.target = TARGET_NONE;
		end else if (wr && a >= STATUS_PORT && a <= BANK_PORT_LAST) begin
			idx = 2'(a - STATUS_PORT);
			latch.rom_bank = idx;
			bank_bytes[idx] = acc.write_data;
			bank_bytes[0] = status_now();
			r.target = TARGET_REG;
			r.mapping_changed = 1'b1;
		end else if (a == CLOCK_PORT_ADDRESS) begin
			if (!latch.kill) begin
				r.target = TARGET_CLOCK;
				if (wr) begin
					r.forward_data = acc.write_data;
				end
			end
		end else if (!wr && a >= IO_ROM_START && a <= IO_ROM_END) begin
			if (!latch.kill) begin
				r.target = TARGET_ROM;
				r.ext_address = base + IO_ROM_BASE + {8'd0, a[7:0]};
			end
		end else if (wr && a >= KILL_PORT && a <= IO_ROM_END && !latch.kill) begin
			r.target = TARGET_REG;
			r.mapping_changed = 1'b1;
			case (a)
				KILL_PORT: begin
					kill_byte = acc.write_data;
					latch.kill = acc.write_data[0];
					if (latch.kill) begin
						latch.mode = MODE_OFF;
						latch.game = 1'b1;
						latch.exrom = 1'b1;
					end else begin
						r.mapping_changed = 1'b0;
					end
				end
				MODE_16K_PORT: begin
					latch.mode = MODE_16K;
					latch.game = 1'b0;
					latch.exrom = 1'b0;
				end
				MODE_8K_PORT: begin
					latch.mode = MODE_8K;
					latch.game = 1'b1;
					latch.exrom = 1'b0;
				end
				MODE_ULTIMAX_PORT: begin
					latch.mode = MODE_ULTIMAX;
					latch.game = 1'b0;
					latch.exrom = 1'b1;
				end
				default: begin
					latch.mode = MODE_OFF;
					latch.game = 1'b1;
					latch.exrom = 1'b1;
				end
			endcase
			if (r.mapping_changed) begin
				bank_bytes[0] = status_now();
			end
		end
		r.game_line = latch.kill | latch.game;
		r.exrom_line = latch.kill | latch.exrom;
		r.mapping_mode = latch.mode;
		r.claims_cpu_access = !latch.kill && ultimax_mode() &&
			(in_ram_window(a) || in_rom_window(a));
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch in %0s: got %h, expected %h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t got;
		rsp_t want;
		if (!arst_n) begin
			latch = CTRL_RESET;
			version = 1'b1;
			bank_bytes[0] = 8'h12;
			bank_bytes[1] = 8'h00;
			bank_bytes[2] = 8'h00;
			bank_bytes[3] = 8'h00;
			kill_byte = 8'h00;
			pending_decodes.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (req.valid && req.ready) begin
				pending_decodes.push_back(decode_access(req.data));
			end
			if (rsp.valid && rsp.ready) begin
				got = rsp.data;
				if (pending_decodes.size() == 0) begin
					report_mismatch("transfer with no access pending", 16'(got.target), 16'h0);
				end else begin
					want = pending_decodes.pop_front();
					if (got.target !== want.target)
						report_mismatch("target", 16'(got.target), 16'(want.target));
					if (got.ext_address !== want.ext_address)
						report_mismatch("ext_address", got.ext_address, want.ext_address);
					if (got.read_data !== want.read_data)
						report_mismatch("read_data", 16'(got.read_data), 16'(want.read_data));
					if (got.forward_data !== want.forward_data)
						report_mismatch("forward_data", 16'(got.forward_data),
							16'(want.forward_data));
					if (got.game_line !== want.game_line)
						report_mismatch("game_line", 16'(got.game_line), 16'(want.game_line));
					if (got.exrom_line !== want.exrom_line)
						report_mismatch("exrom_line", 16'(got.exrom_line), 16'(want.exrom_line));
					if (got.mapping_mode !== want.mapping_mode)
						report_mismatch("mapping_mode", 16'(got.mapping_mode),
							16'(want.mapping_mode));
					if (got.claims_cpu_access !== want.claims_cpu_access)
						report_mismatch("claims_cpu_access", 16'(got.claims_cpu_access),
							16'(want.claims_cpu_access));
					if (got.mapping_changed !== want.mapping_changed)
						report_mismatch("mapping_changed", 16'(got.mapping_changed),
							16'(want.mapping_changed));
				end
			end
			outstanding <= pending_decodes.size();
		end
	end

endmodule

[test/testbench.sv]
// Testbench top: drives CPU accesses and response stalls, and reports the verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ciobd_pkg::*;

	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES = 80;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned mismatches;
	int unsigned outstanding;
	bit          gaps_on = 1'b1;
	bit          hold_request = 1'b0;
	bit          hold_served = 1'b0;

	ciobd_req_if req_ch();
	ciobd_rsp_if rsp_ch();

	cartridge_io_bank_decoder_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	ciobd_decode_checker checker_inst (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #10 clk = ~clk;

	task automatic send_access(input logic act, input logic [15:0] addr,
			input logic [7:0] wd);
		int unsigned pick;
		int unsigned gap;
		req_t        item;
		gap = 0;
		if (gaps_on) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) gap = 0;
			else if (pick < 85) gap = $urandom_range(1, 3);
			else if (pick < 97) gap = $urandom_range(4, 10);
			else gap = $urandom_range(20, 40);
		end
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.action = act;
		item.address = addr;
		item.write_data = wd;
		req_ch.valid <= 1'b1;
		req_ch.data <= item;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic random_access(input bit kill_ok);
		int unsigned pick;
		logic        act;
		logic [15:0] addr;
		logic [7:0]  wd;
		pick = $urandom_range(0, 99);
		act = logic'($urandom_range(0, 1));
		wd = 8'($urandom_range(0, 255));
		if (pick < 20) addr = 16'($urandom_range(RAM_LOW_START, RAM_LOW_END));
		else if (pick < 27) addr = 16'($urandom_range(RAM_HIGH_START, RAM_HIGH_END));
		else if (pick < 39) addr = 16'($urandom_range(ROM_WIN_START, ROM_WIN_END));
		else if (pick < 47) addr = 16'($urandom_range(CTRL_START - 2, CTRL_END + 2));
		else if (pick < 59) addr = 16'($urandom_range(STATUS_PORT - 2, BANK_PORT_LAST + 2));
		else if (pick < 64) addr = 16'(CLOCK_PORT_ADDRESS - 1 + $urandom_range(0, 2));
		else if (pick < 75) addr = 16'($urandom_range(IO_ROM_START, IO_ROM_END));
		else if (pick < 88) begin
			act = ($urandom_range(0, 9) != 0) ? ACTION_WRITE : ACTION_READ;
			if ($urandom_range(0, 9) < 4) addr = MODE_ULTIMAX_PORT;
			else addr = 16'(KILL_PORT + $urandom_range(0, 4));
		end else addr = 16'($urandom_range(0, 16'hFFFF));
		if (!kill_ok && act == ACTION_WRITE && addr == KILL_PORT) wd[0] = 1'b0;
		send_access(act, addr, wd);
	endtask

	initial begin : response_side
		int unsigned span;
		bit          steady;
		rsp_ch.ready <= 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (hold_request && !hold_served) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_served = 1'b1;
			end else begin
				span = $urandom_range(20, 120);
				steady = ($urandom_range(0, 3) == 0);
				repeat (span) begin
					if (hold_request && !hold_served) break;
					if (steady) rsp_ch.ready <= 1'b1;
					else rsp_ch.ready <= ($urandom_range(0, 99) < 70);
					@(posedge clk);
				end
				if (!steady && !(hold_request && !hold_served) &&
						$urandom_range(0, 9) == 0) begin
					rsp_ch.ready <= 1'b0;
					repeat ($urandom_range(15, 40)) @(posedge clk);
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
			else quiet++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed accesses in the reset mapping, then in Ultimax, then mode changes.
		send_access(ACTION_READ, STATUS_PORT, 8'h00);
		send_access(ACTION_READ, STATUS_PORT + 16'd1, 8'hFF);
		send_access(ACTION_WRITE, CTRL_START, 8'hFF);
		send_access(ACTION_READ, CTRL_END, 8'h00);
		send_access(ACTION_READ, CLOCK_PORT_ADDRESS, 8'h00);
		send_access(ACTION_WRITE, CLOCK_PORT_ADDRESS, 8'h00);
		send_access(ACTION_READ, IO_ROM_START, 8'h00);
		send_access(ACTION_READ, IO_ROM_END, 8'h00);
		send_access(ACTION_WRITE, BANK_PORT_LAST, 8'hA5);
		send_access(ACTION_READ, IO_ROM_END, 8'h00);
		send_access(ACTION_WRITE, MODE_ULTIMAX_PORT, 8'h00);
		send_access(ACTION_READ, RAM_LOW_START, 8'h00);
		send_access(ACTION_WRITE, RAM_LOW_END, 8'h5A);
		send_access(ACTION_WRITE, RAM_HIGH_START, 8'hFF);
		send_access(ACTION_READ, RAM_HIGH_END, 8'h00);
		send_access(ACTION_READ, ROM_WIN_START, 8'h00);
		send_access(ACTION_READ, ROM_WIN_END, 8'h00);
		send_access(ACTION_WRITE, ROM_WIN_START, 8'h33);
		send_access(ACTION_READ, 16'h0000, 8'h00);
		send_access(ACTION_WRITE, 16'hFFFF, 8'hFF);
		send_access(ACTION_WRITE, KILL_PORT, 8'hFE);
		send_access(ACTION_WRITE, MODE_16K_PORT, 8'h01);
		send_access(ACTION_WRITE, MODE_8K_PORT, 8'h80);
		send_access(ACTION_WRITE, IO_ROM_END, 8'h7F);
		send_access(ACTION_WRITE, STATUS_PORT, 8'h00);

		for (int i = 0; i < 750; i++) begin
			if (i % 50 == 0) gaps_on = ($urandom_range(0, 3) != 0);
			random_access(1'b0);
		end

		// The response side holds off while accesses keep coming back to back.
		gaps_on = 1'b0;
		hold_request = 1'b1;
		for (int i = 0; i < 30; i++) random_access(1'b0);

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);

		for (int i = 0; i < 750; i++) begin
			if (i % 50 == 0) gaps_on = ($urandom_range(0, 3) != 0);
			random_access(1'b0);
		end

		// The kill latch is sticky, so it is set only for the last stretch.
		gaps_on = 1'b1;
		send_access(ACTION_WRITE, KILL_PORT, 8'($urandom_range(0, 255)) | 8'h01);
		for (int i = 0; i < 100; i++) random_access(1'b1);

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
